// ===== src/httb_pkg.sv =====
// Shared types, constants and the hex digit decode for the hex text parser.
`default_nettype none

package httb_pkg;

   // Character codes of the digit ranges.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Value of the letter digits a and A.
   localparam logic [3:0] LETTER_BASE = 4'd10;

   // Digits that fill one byte.
   localparam logic [1:0] DIGITS_PER_BYTE = 2'd2;

   // Default depth of the queue between the front and the back end.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Result of classifying one character.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } digit_type;

   // One queued entry: the one or two bytes caused by one character, or a bare end marker.
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       first_valid;   // Low when the entry is a bare end marker.
      logic       two_results;
      logic       last;
   } entry_type;

   // Classify a character and give its digit value.
   function automatic digit_type decode_digit(input logic [7:0] c);
      digit_type  d;
      logic [7:0] diff;
      d    = '{is_hex: 1'b0, value: 4'd0};
      diff = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff     = c - CHAR_ZERO;
         d.is_hex = 1'b1;
         d.value  = diff[3:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff     = c - CHAR_LOWER_A;
         d.is_hex = 1'b1;
         d.value  = diff[3:0] + LETTER_BASE;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff     = c - CHAR_UPPER_A;
         d.is_hex = 1'b1;
         d.value  = diff[3:0] + LETTER_BASE;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== src/httb_front.sv =====
// Front end: classifies each character, gathers digits and forms queue entries.
`default_nettype none

module httb_front
   import httb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] text_char,
   input  wire logic       text_last,
   output      logic       entry_push,
   output      entry_type  entry
);

   logic [7:0] acc_ff, acc_in;
   logic [1:0] count_ff, count_in;

   digit_type  dig;
   logic [7:0] acc_mid;
   logic [1:0] count_mid;
   logic [7:0] byte0, byte1;
   logic [1:0] nres;

   // Digit packing for the current character, then the flush on the last one.
   always_comb begin
      dig       = decode_digit(text_char);
      acc_mid   = acc_ff;
      count_mid = count_ff;
      byte0     = 8'd0;
      byte1     = 8'd0;
      nres      = 2'd0;

      if (dig.is_hex) begin
         if (count_ff >= DIGITS_PER_BYTE) begin
            byte0     = acc_ff;
            nres      = 2'd1;
            acc_mid   = {4'd0, dig.value};
            count_mid = 2'd1;
         end else begin
            acc_mid   = {acc_ff[3:0], dig.value};
            count_mid = count_ff + 2'd1;
         end
      end else if (count_ff != 2'd0) begin
         byte0     = acc_ff;
         nres      = 2'd1;
         acc_mid   = 8'd0;
         count_mid = 2'd0;
      end

      // The last character flushes what is still pending.
      if (text_last && count_mid != 2'd0) begin
         if (nres == 2'd0) begin
            byte0 = acc_mid;
         end else begin
            byte1 = acc_mid;
         end
         nres = nres + 2'd1;
      end

      acc_in   = acc_ff;
      count_in = count_ff;
      if (accept) begin
         acc_in   = text_last ? 8'd0 : acc_mid;
         count_in = text_last ? 2'd0 : count_mid;
      end

      entry.first_byte  = byte0;
      entry.second_byte = byte1;
      entry.first_valid = (nres != 2'd0);
      entry.two_results = (nres == 2'd2);
      entry.last        = text_last;
      entry_push        = accept && (nres != 2'd0 || text_last);
   end

   // Digit state.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 8'd0;
         count_ff <= 2'd0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/httb_queue.sv =====
// Short queue of entries between the front and the back end.
`default_nettype none

module httb_queue
   import httb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wr_entry,
   output      logic      full,
   input  wire logic      pop,
   output      entry_type rd_entry,
   output      logic      empty
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]   PTR_ONE    = PTR_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   // Pointer and fill bookkeeping.
   always_comb begin
      full     = (count_ff == COUNT_FULL);
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      rd_entry = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/httb_back.sv =====
// Back end: expands queue entries into result words in an output register.
`default_nettype none

module httb_back
   import httb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire entry_type  head,
   input  wire logic       head_empty,
   output      logic       head_pop,
   input  wire logic       rsp_pop,
   output      logic       rsp_empty,
   output      logic [7:0] rsp_data_byte,
   output      logic       rsp_byte_valid,
   output      logic       rsp_message_end,
   output      logic       rsp_run_last
);

   logic       out_valid_ff, out_valid_in;
   logic       second_ff, second_in;
   logic [7:0] data_ff, data_in;
   logic       bvalid_ff, bvalid_in;
   logic       mend_ff, mend_in;
   logic       rlast_ff, rlast_in;
   logic       load;

   // Load the next result when the output register is free or being taken.
   always_comb begin
      load      = !head_empty && (!out_valid_ff || rsp_pop);
      data_in   = second_ff ? head.second_byte : head.first_byte;
      bvalid_in = second_ff ? 1'b1 : head.first_valid;
      rlast_in  = second_ff || !head.two_results;
      mend_in   = head.last && rlast_in;
      head_pop  = load && rlast_in;

      second_in = second_ff;
      if (load) begin
         second_in = !rlast_in;
      end
      out_valid_in = load || (out_valid_ff && !rsp_pop);

      rsp_empty       = !out_valid_ff;
      rsp_data_byte   = data_ff;
      rsp_byte_valid  = bvalid_ff;
      rsp_message_end = mend_ff;
      rsp_run_last    = rlast_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_in;
         bvalid_ff <= bvalid_in;
         mend_ff   <= mend_in;
         rlast_ff  <= rlast_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/hex_text_to_bytes_parser.sv =====
// Top level of the hex text to byte parser.
//
// Usage: characters enter on the req_ channel, a queue-style port. A word
// is taken at a clock edge with req_push high and req_full low. Hex digits
// are packed two to a byte, high nibble first; other characters are skipped
// but flush one or two pending digits. req_text_last marks the final
// character and flushes whatever is pending.
// Results leave on the rsp_ channel: while rsp_empty is low the oldest word
// is on the rsp_ ports, and it is taken when rsp_pop is high. A character
// gives no word, one word, or two words (a completed pair plus the flushed
// digit of the last character). The last character always gives at least
// one word; with no byte to give, it gives an end marker.
// A result is queued when its character is taken, then passes through the
// output register. Throughput: one character per cycle while req_full is
// low; a character that gives two words holds the output register for both
// in turn, and the entry queue (QUEUE_DEPTH entries) absorbs such bursts.
// Reset clears the digit state, the queue and the output register. When the
// receiver stalls, the output word holds, the queue fills, and req_full
// rises once it has no room left.
`default_nettype none

module hex_text_to_bytes_parser
   import httb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output      logic       req_full,
   input  wire logic [7:0] req_text_char,
   input  wire logic       req_text_last,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop,
   output      logic [7:0] rsp_data_byte,
   output      logic       rsp_byte_valid,
   output      logic       rsp_message_end,
   output      logic       rsp_run_last
);

   logic      accept;
   logic      entry_push;
   entry_type entry;
   entry_type head;
   logic      head_empty;
   logic      head_pop;

   assign accept = req_push && !req_full;

   // Character classification and digit packing.
   httb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_char  (req_text_char),
      .text_last  (req_text_last),
      .entry_push (entry_push),
      .entry      (entry)
   );

   // Decoupling queue.
   httb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_push),
      .wr_entry (entry),
      .full     (req_full),
      .pop      (head_pop),
      .rd_entry (head),
      .empty    (head_empty)
   );

   // Result expansion and output register.
   httb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_empty      (head_empty),
      .head_pop        (head_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

`default_nettype wire
